>>> design/fcs_pkg.sv
package fcs_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int ROI_W   = 11;
    localparam int WT_W    = 28;
    localparam int MOM_W   = 38;
    // 2*moment + weight, and 2*weight
    localparam int NUM_W   = MOM_W + 2;
    localparam int DEN_W   = WT_W + 1;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int IDX_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_ROI_LEFT   = 2'd0,
        CFG_ROI_RIGHT  = 2'd1,
        CFG_ROI_TOP    = 2'd2,
        CFG_ROI_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_DONE
    } fcs_state_t;

    typedef struct packed {
        logic [WT_W-1:0]    weight_total;
        logic [MOM_W-1:0]   col_moment;
        logic [MOM_W-1:0]   row_moment;
        logic [COORD_W-1:0] span;
    } fcs_totals_t;

endpackage

>>> design/fcs_accum.sv
module fcs_accum
    import fcs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               clear,
    input  logic [PIX_W-1:0]   pixel,
    input  logic [COORD_W-1:0] roi_left,
    input  logic [ROI_W-1:0]   roi_right,
    input  logic [COORD_W-1:0] roi_top,
    input  logic [ROI_W-1:0]   roi_bottom,
    output fcs_totals_t        totals
);

    localparam int LIM_W = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1);
    localparam int EXT_W = (LIM_W > ROI_W ? LIM_W : ROI_W) + 1;

    logic [WT_W-1:0]    weight_total_reg, weight_total_next;
    logic [MOM_W-1:0]   col_moment_reg, col_moment_next;
    logic [MOM_W-1:0]   row_moment_reg, row_moment_next;
    logic [COORD_W-1:0] least_col_reg, least_col_next;
    logic [COORD_W-1:0] greatest_col_reg, greatest_col_next;
    logic               seen_reg, seen_next;
    logic [COORD_W-1:0] col_pos_reg, col_pos_next;
    logic [COORD_W-1:0] row_pos_reg, row_pos_next;

    logic [COORD_W-1:0] x, y;
    logic [EXT_W-1:0]   col_clip, row_clip, ncols, nrows;
    logic [COORD_W+PIX_W-1:0] x_prod, y_prod;

    always_comb
    begin
        x = roi_left + col_pos_reg;
        y = roi_top + row_pos_reg;

        // clip region edges, degenerate region is one wide
        col_clip = (EXT_W'(roi_right) < EXT_W'(MAX_COLS)) ? EXT_W'(roi_right)
                                                         : EXT_W'(MAX_COLS);
        row_clip = (EXT_W'(roi_bottom) < EXT_W'(MAX_ROWS)) ? EXT_W'(roi_bottom)
                                                          : EXT_W'(MAX_ROWS);
        ncols = (col_clip > EXT_W'(roi_left)) ? col_clip - EXT_W'(roi_left) : EXT_W'(1);
        nrows = (row_clip > EXT_W'(roi_top)) ? row_clip - EXT_W'(roi_top) : EXT_W'(1);

        x_prod = (COORD_W+PIX_W)'(x) * (COORD_W+PIX_W)'(pixel);
        y_prod = (COORD_W+PIX_W)'(y) * (COORD_W+PIX_W)'(pixel);

        weight_total_next = weight_total_reg;
        col_moment_next   = col_moment_reg;
        row_moment_next   = row_moment_reg;
        least_col_next    = least_col_reg;
        greatest_col_next = greatest_col_reg;
        seen_next         = seen_reg;
        col_pos_next      = col_pos_reg;
        row_pos_next      = row_pos_reg;

        priority if (clear)
        begin
            weight_total_next = '0;
            col_moment_next   = '0;
            row_moment_next   = '0;
            least_col_next    = '1;
            greatest_col_next = '0;
            seen_next         = 1'b0;
            col_pos_next      = '0;
            row_pos_next      = '0;
        end
        else if (step)
        begin
            weight_total_next = weight_total_reg + WT_W'(pixel);
            col_moment_next   = col_moment_reg + MOM_W'(x_prod);
            row_moment_next   = row_moment_reg + MOM_W'(y_prod);
            if (pixel != '0)
            begin
                if (!seen_reg || x < least_col_reg)
                    least_col_next = x;
                if (!seen_reg || x > greatest_col_reg)
                    greatest_col_next = x;
                seen_next = 1'b1;
            end
            // raster walk; rows hold at the last one on overrun
            if (EXT_W'(col_pos_reg) + EXT_W'(1) >= ncols)
            begin
                col_pos_next = '0;
                if (EXT_W'(row_pos_reg) + EXT_W'(1) < nrows)
                    row_pos_next = row_pos_reg + COORD_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COORD_W'(1);
            end
        end
        else
        begin
            // no beat: hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_total_reg <= '0;
            col_moment_reg   <= '0;
            row_moment_reg   <= '0;
            least_col_reg    <= '1;
            greatest_col_reg <= '0;
            seen_reg         <= 1'b0;
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
        end
        else
        begin
            weight_total_reg <= weight_total_next;
            col_moment_reg   <= col_moment_next;
            row_moment_reg   <= row_moment_next;
            least_col_reg    <= least_col_next;
            greatest_col_reg <= greatest_col_next;
            seen_reg         <= seen_next;
            col_pos_reg      <= col_pos_next;
            row_pos_reg      <= row_pos_next;
        end
    end

    assign totals.weight_total = weight_total_reg;
    assign totals.col_moment   = col_moment_reg;
    assign totals.row_moment   = row_moment_reg;
    assign totals.span         = greatest_col_reg - least_col_reg;

endmodule

>>> design/fcs_div.sv
module fcs_div
    import fcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MOM_W-1:0]   moment,
    input  logic [WT_W-1:0]    weight,
    output logic               done,
    output logic [COORD_W-1:0] quot
);

    // restoring divide, one quotient bit per cycle; only low bits kept
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] quot_reg, quot_next;

    logic [DEN_W:0]     trial, diff;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;

        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = {1'b0, moment, 1'b0} + NUM_W'(weight);
            den_next  = {weight, 1'b0};
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[COORD_W-2:0], fits};
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            // idle: hold quotient
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> design/foreground_centroid_span_unit.sv
// Foreground centroid and span of a rectangular region of interest.
// Input channel (in_valid / in_stall): one beat per region pixel in raster
// order, pixel value plus frame_last on the final pixel. Column and row are
// tracked internally from the roi_* registers; nothing but the pixel value
// is carried on the bus.
// Output channel (out_valid / out_stall): one beat per frame carrying the
// rounded weighted centroid, the column span of nonzero pixels and found.
// Throughput: one pixel per clock while a frame is being accumulated.
// After the frame_last beat the block stalls input while one shared
// restoring divider runs first for x and then for y; the result beat
// is loaded into the output register once the y division is done.
// The result sits in an output register; the next frame's pixels are taken
// while it waits. If a second frame finishes before the first result is
// taken, the block holds input stalled until the output register frees.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written by the user
// only when idle, which the block does not enforce; a write takes effect on the next pixel.
// Reset (rst_n, async low): region is full 1024 x 1024, accumulators clear,
// no result pending.
module foreground_centroid_span_unit
    import fcs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [ROI_W-1:0]   cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel,
    input  logic               frame_last,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] centroid_x,
    output logic [COORD_W-1:0] centroid_y,
    output logic [COORD_W-1:0] span,
    output logic               found
);

    // region registers
    logic [COORD_W-1:0] roi_left_reg, roi_top_reg;
    logic [ROI_W-1:0]   roi_right_reg, roi_bottom_reg;

    fcs_state_t  state_reg, state_next;
    fcs_totals_t totals;

    logic               in_accept;
    logic               out_free;
    logic               acc_clear;
    logic               div_start;
    logic               div_done;
    logic [COORD_W-1:0] div_quot;
    logic [MOM_W-1:0]   div_moment;

    logic [COORD_W-1:0] qx_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] cx_reg, cy_reg, span_reg;
    logic               found_reg;
    logic               load_out;
    logic               nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_left_reg   <= '0;
            roi_right_reg  <= ROI_W'(1024);
            roi_top_reg    <= '0;
            roi_bottom_reg <= ROI_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROI_LEFT:   roi_left_reg   <= cfg_data[COORD_W-1:0];
                CFG_ROI_RIGHT:  roi_right_reg  <= cfg_data;
                CFG_ROI_TOP:    roi_top_reg    <= cfg_data[COORD_W-1:0];
                CFG_ROI_BOTTOM: roi_bottom_reg <= cfg_data;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_ACC);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    fcs_accum #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_accept),
        .clear      (acc_clear),
        .pixel      (pixel),
        .roi_left   (roi_left_reg),
        .roi_right  (roi_right_reg),
        .roi_top    (roi_top_reg),
        .roi_bottom (roi_bottom_reg),
        .totals     (totals)
    );

    // x then y through the same divider
    assign div_moment = (state_reg == ST_START_Y) ? totals.row_moment : totals.col_moment;

    fcs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .moment (div_moment),
        .weight (totals.weight_total),
        .done   (div_done),
        .quot   (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_accept && frame_last)
                    state_next = ST_START_X;
            end
            ST_START_X:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (div_done)
                    state_next = ST_START_Y;
            end
            ST_START_Y:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    assign acc_clear = load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT_X && div_done)
            qx_reg <= div_quot;
    end

    // output register
    assign nz = (totals.weight_total != '0);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // nothing found: all fields zero
            cx_reg    <= nz ? qx_reg : '0;
            cy_reg    <= nz ? div_quot : '0;
            span_reg  <= nz ? totals.span : '0;
            found_reg <= nz;
        end
    end

    assign out_valid  = out_valid_reg;
    assign centroid_x = cx_reg;
    assign centroid_y = cy_reg;
    assign span       = span_reg;
    assign found      = found_reg;

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT_X || state_reg == ST_WAIT_Y))
        else $error("divider done outside wait state");

    // last pixel starts the x division
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && frame_last) |=> (state_reg == ST_START_X))
        else $error("frame end did not start division");

    // frame state cleared once the result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (totals.weight_total == '0 && out_valid_reg))
        else $error("accumulators not cleared after result");

    // empty result carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (cx_reg == '0 && cy_reg == '0 && span_reg == '0))
        else $error("nonzero fields with found clear");

endmodule
